@@ hdl/lcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types, constants and character tables of the line command parser.
// ----------------------------------------------------------------------------
package lcp_pkg;

	// Line buffer geometry: the position wraps once it reaches LINE_LEN-1.
	localparam int LINE_LEN = 64;
	localparam int POS_W    = $clog2(LINE_LEN);

	// Command prefix lengths.
	localparam int SET_LEN    = 8;
	localparam int STATUS_LEN = 10;
	// The number starts at the character after the first nine.
	localparam int NUM_START  = 9;

	// Byte and value widths.
	localparam int BYTE_W = 8;
	localparam int FREQ_W = 32;
	localparam int PROD_W = FREQ_W + 4;

	// Magnitude ceiling of the parsed number and the positive maximum.
	localparam logic [FREQ_W-1:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [FREQ_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

	// Line terminators and other special characters.
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_ECHO    = 2'd0,
		KIND_SET     = 2'd1,
		KIND_STATUS  = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	// Number parser phases; the unused code behaves as done.
	typedef enum logic [1:0] {
		PH_SKIP  = 2'd0,
		PH_DIGIT = 2'd1,
		PH_DONE  = 2'd2,
		PH_SPARE = 2'd3
	} phase_t;

	// Item handed from the front part to the back part through the queue.
	typedef struct packed {
		logic                term;
		logic [BYTE_W-1:0]   rx;
		kind_t               kind;
		logic [FREQ_W-1:0]   freq;
	} entry_t;

	// Queue geometry.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Character of the set-frequency command word at a position.
	function automatic logic [BYTE_W-1:0] set_char(input logic [2:0] idx);
		logic [BYTE_W-1:0] ch;
		case (idx)
			3'd0:    ch = 8'h53; // S
			3'd1:    ch = 8'h45; // E
			3'd2:    ch = 8'h54; // T
			3'd3:    ch = 8'h5F; // _
			3'd4:    ch = 8'h46; // F
			3'd5:    ch = 8'h52; // R
			3'd6:    ch = 8'h45; // E
			default: ch = 8'h51; // Q
		endcase
		return ch;
	endfunction

	// Character of the status command word at a position.
	function automatic logic [BYTE_W-1:0] status_char(input logic [3:0] idx);
		logic [BYTE_W-1:0] ch;
		case (idx)
			4'd0:    ch = 8'h47; // G
			4'd1:    ch = 8'h45; // E
			4'd2:    ch = 8'h54; // T
			4'd3:    ch = 8'h5F; // _
			4'd4:    ch = 8'h53; // S
			4'd5:    ch = 8'h54; // T
			4'd6:    ch = 8'h41; // A
			4'd7:    ch = 8'h54; // T
			4'd8:    ch = 8'h55; // U
			4'd9:    ch = 8'h53; // S
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ hdl/lcp_front.sv @@
// ----------------------------------------------------------------------------
// lcp_front
// Accepts received bytes, tracks the line, matches the command prefixes,
// parses the number and builds one queue item per byte.
// ----------------------------------------------------------------------------
module lcp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         q_full,
	input  logic [lcp_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         push,
	output lcp_pkg::entry_t              entry
);

	logic [lcp_pkg::POS_W-1:0]  pos_q;
	logic                       set_ok_q;
	logic                       status_ok_q;
	lcp_pkg::phase_t            phase_q;
	logic                       neg_q;
	logic [lcp_pkg::FREQ_W-1:0] val_q;
	logic [lcp_pkg::FREQ_W-1:0] stored_q;

	logic [lcp_pkg::POS_W-1:0]  pos_e;
	logic                       set_ok_e;
	logic                       status_ok_e;
	lcp_pkg::phase_t            phase_e;
	logic                       neg_e;
	logic [lcp_pkg::FREQ_W-1:0] val_e;

	logic [lcp_pkg::POS_W-1:0]  pos_d;
	logic                       set_ok_d;
	logic                       status_ok_d;
	lcp_pkg::phase_t            phase_d;
	logic                       neg_d;
	logic [lcp_pkg::FREQ_W-1:0] val_d;
	logic [lcp_pkg::FREQ_W-1:0] stored_d;

	logic                       is_term;
	logic                       is_digit;
	logic                       is_space;
	logic [3:0]                 digit;
	logic [lcp_pkg::PROD_W-1:0] prod;
	logic [lcp_pkg::FREQ_W-1:0] prod_sat;
	logic [lcp_pkg::FREQ_W-1:0] num_result;

	assign push = in_valid && !q_full;

	// Byte classes.
	assign is_term  = (rx_byte == lcp_pkg::CH_LF) || (rx_byte == lcp_pkg::CH_CR);
	assign is_digit = rx_byte inside {[lcp_pkg::CH_ZERO:lcp_pkg::CH_NINE]};
	assign is_space = rx_byte inside {lcp_pkg::CH_SPACE, [lcp_pkg::CH_TAB:lcp_pkg::CH_CR]};
	assign digit    = 4'(rx_byte - lcp_pkg::CH_ZERO);

	// Line state as seen by this byte: a full line starts over empty.
	always_comb begin
		if (pos_q >= lcp_pkg::POS_W'(lcp_pkg::LINE_LEN - 1)) begin
			pos_e       = '0;
			set_ok_e    = 1'b1;
			status_ok_e = 1'b1;
			phase_e     = lcp_pkg::PH_SKIP;
			neg_e       = 1'b0;
			val_e       = '0;
		end else begin
			pos_e       = pos_q;
			set_ok_e    = set_ok_q;
			status_ok_e = status_ok_q;
			phase_e     = phase_q;
			neg_e       = neg_q;
			val_e       = val_q;
		end
	end

	// Next magnitude: value times ten plus the digit, saturated at 2^31.
	always_comb begin
		prod = ({4'b0, val_e} << 3) + ({4'b0, val_e} << 1) + lcp_pkg::PROD_W'(digit);
		if (prod > lcp_pkg::PROD_W'(lcp_pkg::MAG_LIMIT)) begin
			prod_sat = lcp_pkg::MAG_LIMIT;
		end else begin
			prod_sat = prod[lcp_pkg::FREQ_W-1:0];
		end
	end

	// Signed value of the number read so far.
	always_comb begin
		if (neg_e) begin
			num_result = '0 - val_e;
		end else if (val_e > lcp_pkg::POS_MAX) begin
			num_result = lcp_pkg::POS_MAX;
		end else begin
			num_result = val_e;
		end
	end

	// Line update and queue item.
	always_comb begin
		pos_d       = pos_e;
		set_ok_d    = set_ok_e;
		status_ok_d = status_ok_e;
		phase_d     = phase_e;
		neg_d       = neg_e;
		val_d       = val_e;
		stored_d    = stored_q;
		entry.term  = is_term;
		entry.rx    = rx_byte;
		entry.kind  = lcp_pkg::KIND_ECHO;
		entry.freq  = '0;
		if (is_term) begin
			// End of line: pick the response, then start a new line.
			if (set_ok_e && (pos_e >= lcp_pkg::POS_W'(lcp_pkg::SET_LEN))) begin
				stored_d   = num_result;
				entry.kind = lcp_pkg::KIND_SET;
				entry.freq = num_result;
			end else if (status_ok_e && (pos_e >= lcp_pkg::POS_W'(lcp_pkg::STATUS_LEN))) begin
				entry.kind = lcp_pkg::KIND_STATUS;
				entry.freq = stored_q;
			end else begin
				entry.kind = lcp_pkg::KIND_UNKNOWN;
			end
			pos_d       = '0;
			set_ok_d    = 1'b1;
			status_ok_d = 1'b1;
			phase_d     = lcp_pkg::PH_SKIP;
			neg_d       = 1'b0;
			val_d       = '0;
		end else begin
			if ((pos_e < lcp_pkg::POS_W'(lcp_pkg::SET_LEN)) &&
			    (rx_byte != lcp_pkg::set_char(pos_e[2:0]))) begin
				set_ok_d = 1'b0;
			end
			if ((pos_e < lcp_pkg::POS_W'(lcp_pkg::STATUS_LEN)) &&
			    (rx_byte != lcp_pkg::status_char(pos_e[3:0]))) begin
				status_ok_d = 1'b0;
			end
			if (pos_e >= lcp_pkg::POS_W'(lcp_pkg::NUM_START)) begin
				case (phase_e)
					lcp_pkg::PH_SKIP: begin
						if (!is_space) begin
							if (rx_byte == lcp_pkg::CH_PLUS) begin
								phase_d = lcp_pkg::PH_DIGIT;
							end else if (rx_byte == lcp_pkg::CH_MINUS) begin
								neg_d   = 1'b1;
								phase_d = lcp_pkg::PH_DIGIT;
							end else if (is_digit) begin
								val_d   = lcp_pkg::FREQ_W'(digit);
								phase_d = lcp_pkg::PH_DIGIT;
							end else begin
								phase_d = lcp_pkg::PH_DONE;
							end
						end
					end
					lcp_pkg::PH_DIGIT: begin
						if (is_digit) begin
							val_d = prod_sat;
						end else begin
							phase_d = lcp_pkg::PH_DONE;
						end
					end
					default: begin
						phase_d = phase_e;
					end
				endcase
			end
			pos_d = pos_e + 1'b1;
		end
	end

	// Line state registers, updated on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			set_ok_q    <= 1'b1;
			status_ok_q <= 1'b1;
			phase_q     <= lcp_pkg::PH_SKIP;
			neg_q       <= 1'b0;
			val_q       <= '0;
			stored_q    <= '0;
		end else if (push) begin
			pos_q       <= pos_d;
			set_ok_q    <= set_ok_d;
			status_ok_q <= status_ok_d;
			phase_q     <= phase_d;
			neg_q       <= neg_d;
			val_q       <= val_d;
			stored_q    <= stored_d;
		end
	end

endmodule

@@ hdl/lcp_queue.sv @@
// ----------------------------------------------------------------------------
// lcp_queue
// Short first-in first-out queue of items between the front and back parts.
// ----------------------------------------------------------------------------
module lcp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lcp_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output lcp_pkg::entry_t head
);

	lcp_pkg::entry_t           slots_q [lcp_pkg::Q_DEPTH];
	logic [lcp_pkg::Q_AW-1:0]  wr_ptr_q;
	logic [lcp_pkg::Q_AW-1:0]  rd_ptr_q;
	logic [lcp_pkg::Q_CW-1:0]  count_q;

	assign full  = (count_q == lcp_pkg::Q_CW'(lcp_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/lcp_back.sv @@
// ----------------------------------------------------------------------------
// lcp_back
// Turns queue items into results: an echo for every byte and, after a line
// terminator, the response. Results sit in an output register.
// ----------------------------------------------------------------------------
module lcp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  lcp_pkg::entry_t             head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [lcp_pkg::BYTE_W-1:0]  echo_byte,
	output logic signed [lcp_pkg::FREQ_W-1:0] frequency,
	output logic                        last
);

	logic                        valid_q;
	logic                        resp_due_q;
	lcp_pkg::kind_t              kind_q;
	logic [lcp_pkg::BYTE_W-1:0]  echo_q;
	logic [lcp_pkg::FREQ_W-1:0]  freq_q;
	logic                        last_q;
	logic                        load;

	// The output register takes a new result when empty or being drained.
	assign load = !q_empty && (!valid_q || !out_stall);
	// A terminator item leaves the queue only with its response.
	assign pop  = load && (!head.term || resp_due_q);

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign echo_byte = echo_q;
	assign frequency = freq_q;
	assign last      = last_q;

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (head.term && resp_due_q) begin
				kind_q <= head.kind;
				echo_q <= '0;
				freq_q <= head.freq;
				last_q <= 1'b1;
			end else begin
				kind_q <= lcp_pkg::KIND_ECHO;
				echo_q <= head.rx;
				freq_q <= '0;
				last_q <= !head.term;
			end
		end
	end

	// Output valid and the pending-response flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			resp_due_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q    <= 1'b1;
				resp_due_q <= head.term && !resp_due_q;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/line_command_parser.sv @@
// ----------------------------------------------------------------------------
// line_command_parser
// Line-oriented command parser: echoes every byte, recognizes the
// set-frequency and status command lines and reports the stored frequency.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   rx_byte
//   out      output     out_valid / out_stall kind, echo_byte, frequency, last
//
// A byte is accepted whenever the four-item queue has room; the
// front part updates the line state in that same cycle.
// The back part gives one result per cycle unless stalled or the queue is
// empty; a plain byte gives one, a terminator two (echo, then response), so
// a line gives one per byte plus one, via the queue and output register.
// Reset clears the line state, the stored frequency, the queue and the output.
// A stall on the output fills the queue, after which in_stall rises.
// ----------------------------------------------------------------------------
module line_command_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lcp_pkg::BYTE_W-1:0]          rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          kind,
	output logic [lcp_pkg::BYTE_W-1:0]          echo_byte,
	output logic signed [lcp_pkg::FREQ_W-1:0]   frequency,
	output logic                                last
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	lcp_pkg::entry_t push_entry;
	lcp_pkg::entry_t head;

	assign in_stall = q_full;

	// Front part: line tracking, prefix match and number parsing.
	lcp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.q_full  (q_full),
		.rx_byte (rx_byte),
		.push    (push),
		.entry   (push_entry)
	);

	// Queue between the two parts.
	lcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	// Back part: result sequencing and output register.
	lcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.echo_byte(echo_byte),
		.frequency(frequency),
		.last     (last)
	);

endmodule

@@ hdl/lcp_checker.sv @@
// ----------------------------------------------------------------------------
// lcp_checker
// Port-level checks of the line command parser, bound to the top level.
// ----------------------------------------------------------------------------
module lcp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [1:0]                         kind,
	input logic [lcp_pkg::BYTE_W-1:0]         echo_byte,
	input logic signed [lcp_pkg::FREQ_W-1:0]  frequency,
	input logic                               last
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// Responses always close the results of their byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != lcp_pkg::KIND_ECHO) |-> last && (echo_byte == '0))
		else $error("response not marked last or carries a byte");

	// Only the echo of a terminator is followed by a further result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (kind == lcp_pkg::KIND_ECHO) &&
			((echo_byte == lcp_pkg::CH_LF) || (echo_byte == lcp_pkg::CH_CR)))
		else $error("non-final result is not a terminator echo");

	// The response follows the terminator echo in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && last && (kind != lcp_pkg::KIND_ECHO))
		else $error("response did not follow terminator echo");

	// Echoes and unknown commands carry no frequency.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == lcp_pkg::KIND_ECHO) || (kind == lcp_pkg::KIND_UNKNOWN))
			|-> (frequency == '0))
		else $error("frequency set on a result that has none");

endmodule

bind line_command_parser lcp_checker u_lcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind     (kind),
	.echo_byte(echo_byte),
	.frequency(frequency),
	.last     (last)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Line command parser testbench
// Sends byte streams made of well-formed set-frequency and status lines,
// broken commands, noise and overlong lines. A model of the parser
// predicts the echo of every byte and the response of every line, and each
// result is checked field by field against it. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Command words in ASCII and the whitespace characters that only the
	// number skips.
	localparam logic [8*lcp_pkg::SET_LEN-1:0]    SET_TEXT    = 64'h5345_545F_4652_4551;
	localparam logic [8*lcp_pkg::STATUS_LEN-1:0] STATUS_TEXT = 80'h4745_545F_5354_4154_5553;
	localparam logic [lcp_pkg::BYTE_W-1:0]       CH_VT       = 8'd11;
	localparam logic [lcp_pkg::BYTE_W-1:0]       CH_FF       = 8'd12;

	// Run control.
	localparam int TARGET_BYTES = 700;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic [lcp_pkg::BYTE_W-1:0] data;
		logic                       hold;
	} tx_item_t;

	typedef struct {
		lcp_pkg::kind_t                    kind;
		logic [lcp_pkg::BYTE_W-1:0]        echo;
		logic signed [lcp_pkg::FREQ_W-1:0] freq;
		logic                              last;
	} reply_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic [lcp_pkg::BYTE_W-1:0]         rx_byte = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic [1:0]                         kind;
	logic [lcp_pkg::BYTE_W-1:0]         echo_byte;
	logic signed [lcp_pkg::FREQ_W-1:0]  frequency;
	logic                               last;

	tx_item_t tx_bytes[$];
	reply_t   expected_results[$];
	logic     hold_next = 1'b0;
	int       bytes_sent = 0;
	int       results_seen = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;

	// Parser state as the model keeps it.
	int                          line_pos = 0;
	logic                        set_match = 1'b1;
	logic                        status_match = 1'b1;
	lcp_pkg::phase_t             num_phase = lcp_pkg::PH_SKIP;
	logic                        num_neg = 1'b0;
	logic [lcp_pkg::FREQ_W-1:0]  num_mag = '0;
	logic [lcp_pkg::FREQ_W-1:0]  freq_stored = '0;

	line_command_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.echo_byte (echo_byte),
		.frequency (frequency),
		.last      (last)
	);

	always #5 clk = ~clk;

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Text of the two command words.
	function automatic string set_word_text();
		return $sformatf("%s", SET_TEXT);
	endfunction

	function automatic string status_word_text();
		return $sformatf("%s", STATUS_TEXT);
	endfunction

	// Starts an empty line: position, prefix matches and number all cleared.
	task automatic restart_line();
		line_pos     = 0;
		set_match    = 1'b1;
		status_match = 1'b1;
		num_phase    = lcp_pkg::PH_SKIP;
		num_neg      = 1'b0;
		num_mag      = '0;
	endtask

	// Advances the line state by one accepted byte and queues its results.
	task automatic parse_byte(input logic [lcp_pkg::BYTE_W-1:0] c);
		reply_t      r;
		logic [63:0] wide;
		logic        is_digit;
		is_digit = (c >= lcp_pkg::CH_ZERO) && (c <= lcp_pkg::CH_NINE);
		if (line_pos >= lcp_pkg::LINE_LEN - 1) begin
			restart_line();
		end
		r.kind = lcp_pkg::KIND_ECHO;
		r.echo = c;
		r.freq = '0;
		r.last = 1'b1;
		if (c == lcp_pkg::CH_LF || c == lcp_pkg::CH_CR) begin
			// A terminator echoes first, then answers the line.
			r.last = 1'b0;
			expected_results.push_back(r);
			r.echo = '0;
			r.last = 1'b1;
			if (set_match && line_pos >= lcp_pkg::SET_LEN) begin
				if (num_neg) begin
					freq_stored = 32'd0 - num_mag;
				end else begin
					freq_stored = (num_mag > lcp_pkg::POS_MAX) ? lcp_pkg::POS_MAX : num_mag;
				end
				r.kind = lcp_pkg::KIND_SET;
				r.freq = freq_stored;
			end else if (status_match && line_pos >= lcp_pkg::STATUS_LEN) begin
				r.kind = lcp_pkg::KIND_STATUS;
				r.freq = freq_stored;
			end else begin
				r.kind = lcp_pkg::KIND_UNKNOWN;
			end
			expected_results.push_back(r);
			restart_line();
		end else begin
			expected_results.push_back(r);
			if (line_pos < lcp_pkg::SET_LEN
					&& c != SET_TEXT[8*(lcp_pkg::SET_LEN-1-line_pos) +: 8]) begin
				set_match = 1'b0;
			end
			if (line_pos < lcp_pkg::STATUS_LEN
					&& c != STATUS_TEXT[8*(lcp_pkg::STATUS_LEN-1-line_pos) +: 8]) begin
				status_match = 1'b0;
			end
			// The number is read like atoi from the tenth character on.
			if (line_pos >= lcp_pkg::NUM_START) begin
				case (num_phase)
					lcp_pkg::PH_SKIP: begin
						if (c == lcp_pkg::CH_SPACE
								|| (c >= lcp_pkg::CH_TAB && c <= lcp_pkg::CH_CR)) begin
						end else if (c == lcp_pkg::CH_PLUS) begin
							num_phase = lcp_pkg::PH_DIGIT;
						end else if (c == lcp_pkg::CH_MINUS) begin
							num_neg   = 1'b1;
							num_phase = lcp_pkg::PH_DIGIT;
						end else if (is_digit) begin
							num_mag   = {24'd0, c - lcp_pkg::CH_ZERO};
							num_phase = lcp_pkg::PH_DIGIT;
						end else begin
							num_phase = lcp_pkg::PH_DONE;
						end
					end
					lcp_pkg::PH_DIGIT: begin
						if (is_digit) begin
							wide = {32'd0, num_mag} * 64'd10 + {56'd0, c - lcp_pkg::CH_ZERO};
							num_mag = (wide > {32'd0, lcp_pkg::MAG_LIMIT})
								? lcp_pkg::MAG_LIMIT : wide[31:0];
						end else begin
							num_phase = lcp_pkg::PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			line_pos++;
		end
	endtask

	// Stimulus building.
	task automatic push_byte(input logic [lcp_pkg::BYTE_W-1:0] b);
		tx_item_t t;
		t.data = b;
		t.hold = hold_next;
		hold_next = 1'b0;
		tx_bytes.push_back(t);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endtask

	function automatic logic [lcp_pkg::BYTE_W-1:0] body_byte();
		logic [lcp_pkg::BYTE_W-1:0] b;
		do begin
			b = $urandom_range(255);
		end while (b == lcp_pkg::CH_LF || b == lcp_pkg::CH_CR);
		return b;
	endfunction

	function automatic logic [lcp_pkg::BYTE_W-1:0] space_byte();
		case ($urandom_range(3))
			0:       return lcp_pkg::CH_TAB;
			1:       return CH_VT;
			2:       return CH_FF;
			default: return lcp_pkg::CH_SPACE;
		endcase
	endfunction

	task automatic push_noise(input int count);
		repeat (count) push_byte(body_byte());
	endtask

	// Argument of a frequency command: separator, whitespace, sign, digits,
	// trailing junk.
	task automatic push_argument();
		logic [63:0] num;
		int          mode;
		push_byte(($urandom_range(3) == 0) ? body_byte() : lcp_pkg::CH_SPACE);
		repeat ($urandom_range(2)) push_byte(space_byte());
		case ($urandom_range(3))
			0:       push_byte(lcp_pkg::CH_PLUS);
			1:       push_byte(lcp_pkg::CH_MINUS);
			default: begin
			end
		endcase
		mode = $urandom_range(4);
		case (mode)
			0:       num = $urandom_range(999);
			1:       num = {32'd0, $urandom};
			2:       num = 64'd2147483640 + $urandom_range(16);
			3:       num = {$urandom, $urandom};
			default: num = '0;
		endcase
		if (mode == 4) begin
			push_noise($urandom_range(2));
		end else begin
			if ($urandom_range(5) == 0) begin
				repeat ($urandom_range(1, 3)) push_byte(lcp_pkg::CH_ZERO);
			end
			push_text($sformatf("%0d", num));
		end
		if ($urandom_range(3) == 0) begin
			push_noise($urandom_range(1, 4));
		end
	endtask

	// One random line, mostly well-formed commands, ended by CR or LF.
	task automatic add_random_line();
		int                          sel;
		int                          spot;
		string                       word;
		logic [lcp_pkg::BYTE_W-1:0]  term;
		sel  = $urandom_range(99);
		term = $urandom_range(1) ? lcp_pkg::CH_CR : lcp_pkg::CH_LF;
		if (sel < 40) begin
			push_text(set_word_text());
			case ($urandom_range(9))
				0:       begin
				end
				1:       push_byte(body_byte());
				default: push_argument();
			endcase
		end else if (sel < 60) begin
			push_text(status_word_text());
			if ($urandom_range(2) == 0) begin
				push_noise($urandom_range(1, 5));
			end
		end else if (sel < 72) begin
			// A command with one character spoiled, sometimes cut short.
			word = $urandom_range(1) ? set_word_text() : status_word_text();
			spot = $urandom_range(word.len() - 1);
			word[spot] = body_byte();
			if ($urandom_range(2) == 0) begin
				word = word.substr(0, $urandom_range(word.len() - 1));
			end
			push_text(word);
			if (word.len() >= lcp_pkg::SET_LEN && $urandom_range(1)) begin
				push_argument();
			end
		end else if (sel < 85) begin
			push_noise($urandom_range(12));
		end else if (sel < 95) begin
			// Overlong lines, some followed by a command after the wrap.
			case ($urandom_range(4))
				0:       push_noise(lcp_pkg::LINE_LEN - 2);
				1:       push_noise(lcp_pkg::LINE_LEN - 1);
				2:       push_noise(lcp_pkg::LINE_LEN);
				default: push_noise($urandom_range(lcp_pkg::LINE_LEN + 1,
						2 * lcp_pkg::LINE_LEN + 10));
			endcase
			if ($urandom_range(1)) begin
				push_noise(lcp_pkg::LINE_LEN - 1 - (tx_bytes.size() % 1));
				if ($urandom_range(1)) begin
					push_text(status_word_text());
				end else begin
					push_text(set_word_text());
					push_argument();
				end
			end
		end else begin
			// Bare terminator pairs give empty lines.
			push_byte($urandom_range(1) ? lcp_pkg::CH_CR : lcp_pkg::CH_LF);
		end
		push_byte(term);
	endtask

	// Driver: offers the next pending byte unless idling or holding for a drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				parse_byte(rx_byte);
				bytes_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_bytes.size() != 0
						&& !(tx_bytes[0].hold && expected_results.size() != 0)
						&& !((bytes_sent < 300 || bytes_sent >= 420)
							&& $urandom_range(99) < 29)) begin
					in_valid <= 1'b1;
					rx_byte  <= tx_bytes[0].data;
					void'(tx_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		reply_t r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, kind", {30'd0, kind}, 32'd0);
				end else begin
					r = expected_results.pop_front();
					if (kind != r.kind) begin
						report_mismatch("kind", {30'd0, kind}, {30'd0, r.kind});
					end
					if (echo_byte != r.echo) begin
						report_mismatch("echo_byte", {24'd0, echo_byte}, {24'd0, r.echo});
					end
					if (frequency != r.freq) begin
						report_mismatch("frequency", frequency, r.freq);
					end
					if (last != r.last) begin
						report_mismatch("last", {31'd0, last}, {31'd0, r.last});
					end
				end
			end
			out_stall <= !(results_seen >= 330 && results_seen < 470)
				&& ($urandom_range(99) < 29);
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int lines;
		lines = 0;
		// Directed lines: negative set, status, short command, extreme bytes,
		// and an empty line.
		push_text($sformatf("%s -7", SET_TEXT));
		push_byte(lcp_pkg::CH_LF);
		push_text(status_word_text());
		push_byte(lcp_pkg::CH_LF);
		push_text(set_word_text());
		push_byte(lcp_pkg::CH_CR);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(lcp_pkg::CH_LF);
		push_byte(lcp_pkg::CH_CR);
		// Random lines; lines 30 and 120, if reached, wait until all results are back.
		while (tx_bytes.size() < TARGET_BYTES) begin
			if (lines == 30 || lines == 120) begin
				hold_next = 1'b1;
			end
			add_random_line();
			lines++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (tx_bytes.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
